[rtl/ipat_pkg.sv]
// Package for the IP allow table with expiry.
// Types, sizes and codes shared by the interfaces, the sequencer and the top level.
// No dependencies.
`default_nettype none

package ipat_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int MAX_WINDOWS = 16;

	localparam int EIDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int ECNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int WIDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int WCNT_W = $clog2(MAX_WINDOWS + 1);

	localparam logic [5:0] EARLY_DENY_RST = 6'd40;

	typedef enum logic [1:0] {
		OP_CLEAR      = 2'd0,
		OP_ADD_ENTRY  = 2'd1,
		OP_ADD_WINDOW = 2'd2,
		OP_QUERY      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_WINDOW       = 3'd1,
		ST_EXPIRED      = 3'd2,
		ST_NOT_FOUND    = 3'd3,
		ST_TABLE_FULL   = 3'd4,
		ST_WINDOWS_FULL = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WIN,
		S_ENT,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] address;
		logic [31:0] expiry_time;
		logic [31:0] now_time;
		logic [2:0]  weekday;
		logic [4:0]  hour_now;
		logic [5:0]  minute_now;
		logic [4:0]  window_from;
		logic [4:0]  window_to;
	} item_t;

	typedef struct packed {
		logic    allowed;
		status_t status;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] address;
		logic [31:0] expiry;
	} ent_word_t;

	typedef struct packed {
		logic [2:0] day;
		logic [4:0] from_hour;
		logic [4:0] to_hour;
	} win_word_t;

	typedef struct packed {
		logic              we;
		logic [EIDX_W-1:0] waddr;
		ent_word_t         wdata;
		logic [EIDX_W-1:0] raddr;
	} ent_ctl_t;

	typedef struct packed {
		logic              we;
		logic [WIDX_W-1:0] waddr;
		win_word_t         wdata;
		logic [WIDX_W-1:0] raddr;
	} win_ctl_t;

endpackage

`default_nettype wire

[rtl/ipat_if.sv]
// Channel interfaces of the IP allow table: request, response, configuration write.
// Depends on ipat_pkg.
`default_nettype none

interface ipat_req_if;
	import ipat_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] address;
	logic [31:0] expiry_time;
	logic [31:0] now_time;
	logic [2:0]  weekday;
	logic [4:0]  hour_now;
	logic [5:0]  minute_now;
	logic [4:0]  window_from;
	logic [4:0]  window_to;

	modport source (output valid, op, address, expiry_time, now_time, weekday, hour_now,
		minute_now, window_from, window_to, input ready);
	modport sink (input valid, op, address, expiry_time, now_time, weekday, hour_now,
		minute_now, window_from, window_to, output ready);
endinterface

interface ipat_rsp_if;
	logic       valid;
	logic       ready;
	logic       allowed;
	logic [2:0] status;

	modport source (output valid, allowed, status, input ready);
	modport sink (input valid, allowed, status, output ready);
endinterface

interface ipat_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/ipat_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ipat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/ipat_seq.sv]
// Operation sequencer: fill counts, window scan, entry scan with expiry invalidation.
// Depends on ipat_pkg; drives the entry and window RAMs in the top level.
`default_nettype none

module ipat_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire ipat_pkg::item_t     item,
	input  wire logic [5:0]          early_deny_minute,
	input  wire logic                out_free,
	output logic                     done,
	output ipat_pkg::result_t        result,
	output ipat_pkg::ent_ctl_t       ent_ctl,
	input  wire ipat_pkg::ent_word_t ent_rdata,
	output ipat_pkg::win_ctl_t       win_ctl,
	input  wire ipat_pkg::win_word_t win_rdata
);
	import ipat_pkg::*;

	state_t            state_q, state_d;
	item_t             item_q;
	result_t           res_q, res_d;
	logic [ECNT_W-1:0] ent_cnt_q, ent_cnt_d;
	logic [WCNT_W-1:0] win_cnt_q, win_cnt_d;
	logic [EIDX_W-1:0] ent_idx_q, ent_idx_d;
	logic [WIDX_W-1:0] win_idx_q, win_idx_d;
	logic              win_hit;
	logic              ent_hit;
	logic              win_last;
	logic              ent_last;

	assign result = res_q;

	always_comb begin
		win_hit = (win_rdata.day == item_q.weekday) &&
			(((item_q.hour_now >= win_rdata.from_hour) &&
			  (item_q.hour_now <= win_rdata.to_hour)) ||
			 ((win_rdata.from_hour != 5'd0) &&
			  (item_q.hour_now == win_rdata.from_hour - 5'd1) &&
			  (item_q.minute_now > early_deny_minute)));
		ent_hit  = ent_rdata.valid && (ent_rdata.address == item_q.address);
		win_last = (WCNT_W'(win_idx_q) + WCNT_W'(1)) == win_cnt_q;
		ent_last = (ECNT_W'(ent_idx_q) + ECNT_W'(1)) == ent_cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ent_cnt_q <= '0;
			win_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			ent_cnt_q <= ent_cnt_d;
			win_cnt_q <= win_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item;
		end
		res_q     <= res_d;
		ent_idx_q <= ent_idx_d;
		win_idx_q <= win_idx_d;
	end

	always_comb begin
		state_d   = state_q;
		ent_cnt_d = ent_cnt_q;
		win_cnt_d = win_cnt_q;
		ent_idx_d = ent_idx_q;
		win_idx_d = win_idx_q;
		res_d     = res_q;
		in_ready  = 1'b0;
		done      = 1'b0;
		ent_ctl   = '0;
		win_ctl   = '0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					res_d.allowed = 1'b0;
					res_d.status  = ST_OK;
					ent_idx_d     = '0;
					win_idx_d     = '0;
					state_d       = S_DONE;
					unique case (item.op)
						OP_CLEAR: begin
							ent_cnt_d = '0;
							win_cnt_d = '0;
						end
						OP_ADD_ENTRY: begin
							if (ent_cnt_q == ECNT_W'(MAX_ENTRIES)) begin
								res_d.status = ST_TABLE_FULL;
							end else begin
								ent_ctl.we            = 1'b1;
								ent_ctl.waddr         = ent_cnt_q[EIDX_W-1:0];
								ent_ctl.wdata.valid   = 1'b1;
								ent_ctl.wdata.address = item.address;
								ent_ctl.wdata.expiry  = item.expiry_time;
								ent_cnt_d             = ent_cnt_q + ECNT_W'(1);
							end
						end
						OP_ADD_WINDOW: begin
							if (win_cnt_q == WCNT_W'(MAX_WINDOWS)) begin
								res_d.status = ST_WINDOWS_FULL;
							end else begin
								win_ctl.we              = 1'b1;
								win_ctl.waddr           = win_cnt_q[WIDX_W-1:0];
								win_ctl.wdata.day       = item.weekday;
								win_ctl.wdata.from_hour = item.window_from;
								win_ctl.wdata.to_hour   = item.window_to;
								win_cnt_d               = win_cnt_q + WCNT_W'(1);
							end
						end
						OP_QUERY: begin
							if (win_cnt_q != '0) begin
								state_d = S_WIN;
							end else if (ent_cnt_q != '0) begin
								state_d = S_ENT;
							end else begin
								res_d.status = ST_NOT_FOUND;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_WIN: begin
				win_ctl.raddr = win_idx_q + WIDX_W'(1);
				if (win_hit) begin
					res_d.status = ST_WINDOW;
					state_d      = S_DONE;
				end else if (win_last) begin
					if (ent_cnt_q != '0) begin
						state_d = S_ENT;
					end else begin
						res_d.status = ST_NOT_FOUND;
						state_d      = S_DONE;
					end
				end else begin
					win_idx_d = win_idx_q + WIDX_W'(1);
				end
			end
			S_ENT: begin
				ent_ctl.raddr = ent_idx_q + EIDX_W'(1);
				if (ent_hit) begin
					if (item_q.now_time > ent_rdata.expiry) begin
						ent_ctl.we          = 1'b1;
						ent_ctl.waddr       = ent_idx_q;
						ent_ctl.wdata       = ent_rdata;
						ent_ctl.wdata.valid = 1'b0;
						res_d.status        = ST_EXPIRED;
					end else begin
						res_d.allowed = 1'b1;
						res_d.status  = ST_OK;
					end
					state_d = S_DONE;
				end else if (ent_last) begin
					res_d.status = ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					ent_idx_d = ent_idx_q + EIDX_W'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_ent_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ent_cnt_q <= ECNT_W'(MAX_ENTRIES))
		else $error("entry count beyond capacity");
	a_win_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_cnt_q <= WCNT_W'(MAX_WINDOWS))
		else $error("window count beyond capacity");
	a_ent_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ENT) |-> (ECNT_W'(ent_idx_q) < ent_cnt_q))
		else $error("entry scan beyond fill count");
	a_win_scan_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WIN) |-> (WCNT_W'(win_idx_q) < win_cnt_q))
		else $error("window scan beyond fill count");
	a_invalidate_expired: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ENT && ent_ctl.we) |=> (res_q.status == ST_EXPIRED && state_q == S_DONE))
		else $error("invalidation without expired result");
`endif

endmodule

`default_nettype wire

[rtl/ip_allow_table_with_expiry.sv]
// IP allow table with expiry: top level with channels, config register, output register.
// Depends on ipat_pkg, ipat_if, ipat_ram and ipat_seq.
//
// Usage:
//   req  - one operation per transfer: clear, add entry, add deny window, query.
//   rsp  - exactly one result (allowed, status) per request, in request order.
//   cfg  - write of early_deny_minute (6 bits); always ready, write only while idle.
// Sequencing:
//   clear and both adds act in the idle state, then wait in the done state.
//   a query scans W windows (up to the window count) and
//   E entries (up to the entry count, 1024 at most); the entry RAM read
//   port walks one entry a cycle, the window RAM one window a cycle.
// Reset: counts empty, early_deny_minute = 40; no clearing pass, fill counts bound reads.
// Stall: the result sits in an output register; the next request is taken while it
//   waits, and its result holds in the sequencer until the output register frees.
`default_nettype none

module ip_allow_table_with_expiry (
	input wire logic     clk,
	input wire logic     arst_n,
	ipat_req_if.sink     req,
	ipat_rsp_if.source   rsp,
	ipat_cfg_if.sink     cfg
);
	import ipat_pkg::*;

	logic [5:0] early_deny_q;
	logic       out_valid_q;
	result_t    out_res_q;
	logic       out_free;
	logic       seq_done;
	result_t    seq_res;
	item_t      item;
	ent_ctl_t   ent_ctl;
	ent_word_t  ent_rdata;
	win_ctl_t   win_ctl;
	win_word_t  win_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			early_deny_q <= EARLY_DENY_RST;
		end else if (cfg.valid) begin
			early_deny_q <= cfg.data;
		end
	end

	always_comb begin
		item.op          = op_t'(req.op);
		item.address     = req.address;
		item.expiry_time = req.expiry_time;
		item.now_time    = req.now_time;
		item.weekday     = req.weekday;
		item.hour_now    = req.hour_now;
		item.minute_now  = req.minute_now;
		item.window_from = req.window_from;
		item.window_to   = req.window_to;
	end

	assign out_free = !out_valid_q || rsp.ready;

	ipat_seq u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (req.valid),
		.in_ready          (req.ready),
		.item              (item),
		.early_deny_minute (early_deny_q),
		.out_free          (out_free),
		.done              (seq_done),
		.result            (seq_res),
		.ent_ctl           (ent_ctl),
		.ent_rdata         (ent_rdata),
		.win_ctl           (win_ctl),
		.win_rdata         (win_rdata)
	);

	ipat_ram #(
		.WIDTH ($bits(ent_word_t)),
		.DEPTH (MAX_ENTRIES),
		.AW    (EIDX_W)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_ctl.we),
		.waddr (ent_ctl.waddr),
		.wdata (ent_ctl.wdata),
		.raddr (ent_ctl.raddr),
		.rdata (ent_rdata)
	);

	ipat_ram #(
		.WIDTH ($bits(win_word_t)),
		.DEPTH (MAX_WINDOWS),
		.AW    (WIDX_W)
	) u_win_ram (
		.clk   (clk),
		.we    (win_ctl.we),
		.waddr (win_ctl.waddr),
		.wdata (win_ctl.wdata),
		.raddr (win_ctl.raddr),
		.rdata (win_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			out_res_q <= seq_res;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.allowed = out_res_q.allowed;
	assign rsp.status  = out_res_q.status;

endmodule

`default_nettype wire
